[rtl/ppcdec_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcdec_pkg
// types, codes and opcode lookup tables of the instruction decoder
// ----------------------------------------------------------------------------
package ppcdec_pkg;

  // decode status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_FPU  = 3'd1;
  localparam logic [2:0] ST_NO_VEC  = 3'd2;
  localparam logic [2:0] ST_ILLEGAL = 3'd3;
  localparam logic [2:0] ST_OSI     = 3'd4;
  localparam logic [2:0] ST_MEMSET  = 3'd5;
  localparam logic [2:0] ST_MEMCPY  = 3'd6;
  localparam logic [2:0] ST_STOP    = 3'd7;

  // configuration register indexes
  localparam logic [1:0] CFG_ALTIVEC   = 2'd0;
  localparam logic [1:0] CFG_OSI_ENTRY = 2'd1;
  localparam logic [1:0] CFG_OSI_MAGIC = 2'd2;

  // hook words
  localparam logic [31:0] HOOK_MEMSET = 32'h0033_3301;
  localparam logic [31:0] HOOK_MEMCPY = 32'h0033_3302;
  localparam logic [31:0] HOOK_STOP   = 32'h0000_5AF0;

  // first handler number of each table; the sub-opcode limit of the vector table
  localparam logic [8:0] BASE_OP31 = 9'd59;
  localparam logic [8:0] BASE_VCMP = 9'd218;
  localparam logic [8:0] BASE_VTAB = 9'd231;
  localparam logic [9:0] VEC_EXT_LIMIT = 10'd965;

  // opcode-31 entry kinds
  localparam logic [1:0] K_PLAIN = 2'd0;
  localparam logic [1:0] K_RC    = 2'd1;
  localparam logic [1:0] K_FP    = 2'd2;
  localparam logic [1:0] K_VEC   = 2'd3;

  typedef struct packed {
    logic        altivec_present;
    logic [31:0] osi_entry_address;
    logic [31:0] osi_magic_word;
  } cfg_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] kind;
    logic [6:0] idx;
  } op31_t;

  typedef struct packed {
    logic [8:0] id;
    logic       rc;
    logic       lk;
    logic       aa;
    logic       fpk;
    logic       fp;
    logic       novec;
    logic       osi_hit;
    logic       hk_memset;
    logic       hk_memcpy;
    logic       hk_stop;
  } dec_t;

  function automatic op31_t op31_lookup(input logic [9:0] s);
    op31_t r;
    r = '{1'b0, K_PLAIN, 7'd0};
    case (s)
      10'd0:   r = '{1'b1, K_PLAIN, 7'd0};
      10'd4:   r = '{1'b1, K_PLAIN, 7'd1};
      10'd8:   r = '{1'b1, K_RC,    7'd2};
      10'd10:  r = '{1'b1, K_RC,    7'd3};
      10'd11:  r = '{1'b1, K_RC,    7'd4};
      10'd19:  r = '{1'b1, K_PLAIN, 7'd5};
      10'd20:  r = '{1'b1, K_PLAIN, 7'd6};
      10'd23:  r = '{1'b1, K_PLAIN, 7'd7};
      10'd24:  r = '{1'b1, K_RC,    7'd8};
      10'd26:  r = '{1'b1, K_RC,    7'd9};
      10'd28:  r = '{1'b1, K_RC,    7'd10};
      10'd32:  r = '{1'b1, K_PLAIN, 7'd11};
      10'd40:  r = '{1'b1, K_RC,    7'd12};
      10'd54:  r = '{1'b1, K_PLAIN, 7'd13};
      10'd55:  r = '{1'b1, K_PLAIN, 7'd14};
      10'd60:  r = '{1'b1, K_RC,    7'd15};
      10'd75:  r = '{1'b1, K_RC,    7'd16};
      10'd83:  r = '{1'b1, K_PLAIN, 7'd17};
      10'd86:  r = '{1'b1, K_PLAIN, 7'd18};
      10'd87:  r = '{1'b1, K_PLAIN, 7'd19};
      10'd104: r = '{1'b1, K_RC,    7'd20};
      10'd119: r = '{1'b1, K_PLAIN, 7'd21};
      10'd124: r = '{1'b1, K_RC,    7'd22};
      10'd136: r = '{1'b1, K_RC,    7'd23};
      10'd138: r = '{1'b1, K_RC,    7'd24};
      10'd144: r = '{1'b1, K_PLAIN, 7'd25};
      10'd146: r = '{1'b1, K_PLAIN, 7'd26};
      10'd150: r = '{1'b1, K_PLAIN, 7'd27};
      10'd151: r = '{1'b1, K_PLAIN, 7'd28};
      10'd183: r = '{1'b1, K_PLAIN, 7'd29};
      10'd200: r = '{1'b1, K_RC,    7'd30};
      10'd202: r = '{1'b1, K_RC,    7'd31};
      10'd210: r = '{1'b1, K_PLAIN, 7'd32};
      10'd215: r = '{1'b1, K_PLAIN, 7'd33};
      10'd232: r = '{1'b1, K_RC,    7'd34};
      10'd234: r = '{1'b1, K_RC,    7'd35};
      10'd235: r = '{1'b1, K_RC,    7'd36};
      10'd242: r = '{1'b1, K_PLAIN, 7'd37};
      10'd246: r = '{1'b1, K_PLAIN, 7'd38};
      10'd247: r = '{1'b1, K_PLAIN, 7'd39};
      10'd266: r = '{1'b1, K_RC,    7'd40};
      10'd278: r = '{1'b1, K_PLAIN, 7'd41};
      10'd279: r = '{1'b1, K_PLAIN, 7'd42};
      10'd284: r = '{1'b1, K_RC,    7'd43};
      10'd306: r = '{1'b1, K_PLAIN, 7'd44};
      10'd310: r = '{1'b1, K_PLAIN, 7'd45};
      10'd311: r = '{1'b1, K_PLAIN, 7'd46};
      10'd316: r = '{1'b1, K_RC,    7'd47};
      10'd339: r = '{1'b1, K_PLAIN, 7'd48};
      10'd343: r = '{1'b1, K_PLAIN, 7'd49};
      10'd370: r = '{1'b1, K_PLAIN, 7'd50};
      10'd371: r = '{1'b1, K_PLAIN, 7'd51};
      10'd375: r = '{1'b1, K_PLAIN, 7'd52};
      10'd407: r = '{1'b1, K_PLAIN, 7'd53};
      10'd412: r = '{1'b1, K_RC,    7'd54};
      10'd438: r = '{1'b1, K_PLAIN, 7'd55};
      10'd439: r = '{1'b1, K_PLAIN, 7'd56};
      10'd444: r = '{1'b1, K_RC,    7'd57};
      10'd459: r = '{1'b1, K_RC,    7'd58};
      10'd467: r = '{1'b1, K_PLAIN, 7'd59};
      10'd470: r = '{1'b1, K_PLAIN, 7'd60};
      10'd476: r = '{1'b1, K_RC,    7'd61};
      10'd491: r = '{1'b1, K_RC,    7'd62};
      10'd512: r = '{1'b1, K_PLAIN, 7'd63};
      10'd533: r = '{1'b1, K_PLAIN, 7'd64};
      10'd534: r = '{1'b1, K_PLAIN, 7'd65};
      10'd535: r = '{1'b1, K_FP,    7'd66};
      10'd536: r = '{1'b1, K_RC,    7'd67};
      10'd566: r = '{1'b1, K_PLAIN, 7'd68};
      10'd567: r = '{1'b1, K_FP,    7'd69};
      10'd595: r = '{1'b1, K_PLAIN, 7'd70};
      10'd597: r = '{1'b1, K_PLAIN, 7'd71};
      10'd598: r = '{1'b1, K_PLAIN, 7'd72};
      10'd599: r = '{1'b1, K_FP,    7'd73};
      10'd631: r = '{1'b1, K_FP,    7'd74};
      10'd659: r = '{1'b1, K_PLAIN, 7'd75};
      10'd661: r = '{1'b1, K_PLAIN, 7'd76};
      10'd662: r = '{1'b1, K_PLAIN, 7'd77};
      10'd663: r = '{1'b1, K_FP,    7'd78};
      10'd695: r = '{1'b1, K_FP,    7'd79};
      10'd725: r = '{1'b1, K_PLAIN, 7'd80};
      10'd727: r = '{1'b1, K_FP,    7'd81};
      10'd758: r = '{1'b1, K_PLAIN, 7'd82};
      10'd759: r = '{1'b1, K_FP,    7'd83};
      10'd790: r = '{1'b1, K_PLAIN, 7'd84};
      10'd792: r = '{1'b1, K_RC,    7'd85};
      10'd824: r = '{1'b1, K_RC,    7'd86};
      10'd854: r = '{1'b1, K_PLAIN, 7'd87};
      10'd918: r = '{1'b1, K_PLAIN, 7'd88};
      10'd922: r = '{1'b1, K_RC,    7'd89};
      10'd954: r = '{1'b1, K_RC,    7'd90};
      10'd982: r = '{1'b1, K_PLAIN, 7'd91};
      10'd983: r = '{1'b1, K_FP,    7'd92};
      10'd1014: r = '{1'b1, K_PLAIN, 7'd93};
      10'd6:   r = '{1'b1, K_VEC,   7'd94};
      10'd7:   r = '{1'b1, K_VEC,   7'd95};
      10'd38:  r = '{1'b1, K_VEC,   7'd96};
      10'd39:  r = '{1'b1, K_VEC,   7'd97};
      10'd71:  r = '{1'b1, K_VEC,   7'd98};
      10'd103: r = '{1'b1, K_VEC,   7'd99};
      10'd135: r = '{1'b1, K_VEC,   7'd100};
      10'd167: r = '{1'b1, K_VEC,   7'd101};
      10'd199: r = '{1'b1, K_VEC,   7'd102};
      10'd231: r = '{1'b1, K_VEC,   7'd103};
      10'd342: r = '{1'b1, K_VEC,   7'd104};
      10'd359: r = '{1'b1, K_VEC,   7'd105};
      10'd374: r = '{1'b1, K_VEC,   7'd106};
      10'd487: r = '{1'b1, K_VEC,   7'd107};
      10'd822: r = '{1'b1, K_VEC,   7'd108};
      default: r = '{1'b0, K_PLAIN, 7'd0};
    endcase
    return r;
  endfunction

  // opcode 19, exact match on the low eleven bits
  function automatic logic [8:0] op19_id(input logic [10:0] m);
    logic [8:0] r;
    case (m)
      11'd0:    r = 9'd43;
      11'd32:   r = 9'd44;
      11'd33:   r = 9'd44;
      11'd66:   r = 9'd45;
      11'd100:  r = 9'd46;
      11'd258:  r = 9'd47;
      11'd300:  r = 9'd48;
      11'd386:  r = 9'd49;
      11'd450:  r = 9'd50;
      11'd514:  r = 9'd51;
      11'd578:  r = 9'd52;
      11'd834:  r = 9'd53;
      11'd898:  r = 9'd54;
      11'd1056: r = 9'd55;
      11'd1057: r = 9'd55;
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] op59_id(input logic [4:0] s);
    logic [8:0] r;
    case (s)
      5'd18: r = 9'd168;
      5'd20: r = 9'd169;
      5'd21: r = 9'd170;
      5'd22: r = 9'd171;
      5'd24: r = 9'd172;
      5'd25: r = 9'd173;
      5'd28: r = 9'd174;
      5'd29: r = 9'd175;
      5'd30: r = 9'd176;
      5'd31: r = 9'd177;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] op63a_id(input logic [4:0] s);
    logic [8:0] r;
    case (s)
      5'd18: r = 9'd178;
      5'd20: r = 9'd179;
      5'd21: r = 9'd180;
      5'd22: r = 9'd181;
      5'd23: r = 9'd182;
      5'd25: r = 9'd183;
      5'd26: r = 9'd184;
      5'd28: r = 9'd185;
      5'd29: r = 9'd186;
      5'd30: r = 9'd187;
      5'd31: r = 9'd188;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] op63b_id(input logic [9:0] s);
    logic [8:0] r;
    case (s)
      10'd0:   r = 9'd189;
      10'd12:  r = 9'd190;
      10'd14:  r = 9'd191;
      10'd15:  r = 9'd192;
      10'd32:  r = 9'd193;
      10'd38:  r = 9'd194;
      10'd40:  r = 9'd195;
      10'd64:  r = 9'd196;
      10'd70:  r = 9'd197;
      10'd72:  r = 9'd198;
      10'd134: r = 9'd199;
      10'd136: r = 9'd200;
      10'd264: r = 9'd201;
      10'd583: r = 9'd202;
      10'd711: r = 9'd203;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // vector compares: {hit, index}
  function automatic logic [4:0] vcmp_lookup(input logic [8:0] s);
    logic [4:0] r;
    case (s)
      9'd3:   r = {1'b1, 4'd0};
      9'd35:  r = {1'b1, 4'd1};
      9'd67:  r = {1'b1, 4'd2};
      9'd99:  r = {1'b1, 4'd3};
      9'd227: r = {1'b1, 4'd4};
      9'd259: r = {1'b1, 4'd5};
      9'd291: r = {1'b1, 4'd6};
      9'd323: r = {1'b1, 4'd7};
      9'd355: r = {1'b1, 4'd8};
      9'd387: r = {1'b1, 4'd9};
      9'd419: r = {1'b1, 4'd10};
      9'd451: r = {1'b1, 4'd11};
      9'd483: r = {1'b1, 4'd12};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // vector table: {hit, index}
  function automatic logic [7:0] vtab_lookup(input logic [9:0] s);
    logic [7:0] r;
    case (s)
      10'd0:   r = {1'b1, 7'd0};   10'd1:   r = {1'b1, 7'd1};
      10'd2:   r = {1'b1, 7'd2};   10'd4:   r = {1'b1, 7'd3};
      10'd5:   r = {1'b1, 7'd4};   10'd6:   r = {1'b1, 7'd5};
      10'd7:   r = {1'b1, 7'd6};   10'd32:  r = {1'b1, 7'd7};
      10'd33:  r = {1'b1, 7'd8};   10'd34:  r = {1'b1, 7'd9};
      10'd36:  r = {1'b1, 7'd10};  10'd37:  r = {1'b1, 7'd11};
      10'd38:  r = {1'b1, 7'd12};  10'd39:  r = {1'b1, 7'd13};
      10'd64:  r = {1'b1, 7'd14};  10'd65:  r = {1'b1, 7'd15};
      10'd66:  r = {1'b1, 7'd16};  10'd70:  r = {1'b1, 7'd17};
      10'd71:  r = {1'b1, 7'd18};  10'd103: r = {1'b1, 7'd19};
      10'd129: r = {1'b1, 7'd20};  10'd130: r = {1'b1, 7'd21};
      10'd132: r = {1'b1, 7'd22};  10'd133: r = {1'b1, 7'd23};
      10'd134: r = {1'b1, 7'd24};  10'd135: r = {1'b1, 7'd25};
      10'd161: r = {1'b1, 7'd26};  10'd162: r = {1'b1, 7'd27};
      10'd164: r = {1'b1, 7'd28};  10'd165: r = {1'b1, 7'd29};
      10'd166: r = {1'b1, 7'd30};  10'd167: r = {1'b1, 7'd31};
      10'd192: r = {1'b1, 7'd32};  10'd193: r = {1'b1, 7'd33};
      10'd194: r = {1'b1, 7'd34};  10'd197: r = {1'b1, 7'd35};
      10'd198: r = {1'b1, 7'd36};  10'd199: r = {1'b1, 7'd37};
      10'd226: r = {1'b1, 7'd38};  10'd229: r = {1'b1, 7'd39};
      10'd231: r = {1'b1, 7'd40};  10'd256: r = {1'b1, 7'd41};
      10'd257: r = {1'b1, 7'd42};  10'd258: r = {1'b1, 7'd43};
      10'd260: r = {1'b1, 7'd44};  10'd261: r = {1'b1, 7'd45};
      10'd262: r = {1'b1, 7'd46};  10'd263: r = {1'b1, 7'd47};
      10'd288: r = {1'b1, 7'd48};  10'd289: r = {1'b1, 7'd49};
      10'd290: r = {1'b1, 7'd50};  10'd292: r = {1'b1, 7'd51};
      10'd293: r = {1'b1, 7'd52};  10'd294: r = {1'b1, 7'd53};
      10'd295: r = {1'b1, 7'd54};  10'd320: r = {1'b1, 7'd55};
      10'd321: r = {1'b1, 7'd56};  10'd322: r = {1'b1, 7'd57};
      10'd325: r = {1'b1, 7'd58};  10'd326: r = {1'b1, 7'd59};
      10'd327: r = {1'b1, 7'd60};  10'd354: r = {1'b1, 7'd61};
      10'd357: r = {1'b1, 7'd62};  10'd359: r = {1'b1, 7'd63};
      10'd384: r = {1'b1, 7'd64};  10'd385: r = {1'b1, 7'd65};
      10'd386: r = {1'b1, 7'd66};  10'd388: r = {1'b1, 7'd67};
      10'd389: r = {1'b1, 7'd68};  10'd390: r = {1'b1, 7'd69};
      10'd391: r = {1'b1, 7'd70};  10'd416: r = {1'b1, 7'd71};
      10'd417: r = {1'b1, 7'd72};  10'd418: r = {1'b1, 7'd73};
      10'd420: r = {1'b1, 7'd74};  10'd421: r = {1'b1, 7'd75};
      10'd422: r = {1'b1, 7'd76};  10'd423: r = {1'b1, 7'd77};
      10'd448: r = {1'b1, 7'd78};  10'd449: r = {1'b1, 7'd79};
      10'd450: r = {1'b1, 7'd80};  10'd453: r = {1'b1, 7'd81};
      10'd454: r = {1'b1, 7'd82};  10'd485: r = {1'b1, 7'd83};
      10'd487: r = {1'b1, 7'd84};  10'd512: r = {1'b1, 7'd85};
      10'd513: r = {1'b1, 7'd86};  10'd514: r = {1'b1, 7'd87};
      10'd517: r = {1'b1, 7'd88};  10'd518: r = {1'b1, 7'd89};
      10'd544: r = {1'b1, 7'd90};  10'd545: r = {1'b1, 7'd91};
      10'd546: r = {1'b1, 7'd92};  10'd549: r = {1'b1, 7'd93};
      10'd550: r = {1'b1, 7'd94};  10'd576: r = {1'b1, 7'd95};
      10'd577: r = {1'b1, 7'd96};  10'd578: r = {1'b1, 7'd97};
      10'd610: r = {1'b1, 7'd98};  10'd641: r = {1'b1, 7'd99};
      10'd642: r = {1'b1, 7'd100}; 10'd673: r = {1'b1, 7'd101};
      10'd704: r = {1'b1, 7'd102}; 10'd705: r = {1'b1, 7'd103};
      10'd768: r = {1'b1, 7'd104}; 10'd770: r = {1'b1, 7'd105};
      10'd772: r = {1'b1, 7'd106}; 10'd800: r = {1'b1, 7'd107};
      10'd802: r = {1'b1, 7'd108}; 10'd804: r = {1'b1, 7'd109};
      10'd832: r = {1'b1, 7'd110}; 10'd836: r = {1'b1, 7'd111};
      10'd896: r = {1'b1, 7'd112}; 10'd900: r = {1'b1, 7'd113};
      10'd928: r = {1'b1, 7'd114}; 10'd960: r = {1'b1, 7'd115};
      10'd964: r = {1'b1, 7'd116};
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

[rtl/ppcdec_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcdec_if
// handshake channels of the instruction decoder
// ----------------------------------------------------------------------------
interface ppcdec_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;
  logic [31:0] program_counter;
  logic        fp_enabled;
  logic        vec_enabled;
  modport source (output valid, instruction_word, program_counter, fp_enabled,
                  vec_enabled, input ready);
  modport sink (input valid, instruction_word, program_counter, fp_enabled,
                vec_enabled, output ready);
endinterface

interface ppcdec_out_if;
  logic       valid;
  logic       ready;
  logic [8:0] handler_id;
  logic [2:0] decode_status;
  logic       record_flag;
  logic       link_flag;
  logic       absolute_flag;
  modport source (output valid, handler_id, decode_status, record_flag, link_flag,
                  absolute_flag, input ready);
  modport sink (input valid, handler_id, decode_status, record_flag, link_flag,
                absolute_flag, output ready);
endinterface

interface ppcdec_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/ppcdec_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcdec_cfg
// configuration register file, always ready
// ----------------------------------------------------------------------------
module ppcdec_cfg (
  input  logic              clk,
  input  logic              rst,
  ppcdec_cfg_if.sink        cfg,
  output ppcdec_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        ppcdec_pkg::CFG_ALTIVEC:   regs.altivec_present   <= cfg.data[0];
        ppcdec_pkg::CFG_OSI_ENTRY: regs.osi_entry_address <= cfg.data;
        ppcdec_pkg::CFG_OSI_MAGIC: regs.osi_magic_word    <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/ppcdec_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcdec_lookup
// table lookup stage: word to handler number and flags, registered
// ----------------------------------------------------------------------------
module ppcdec_lookup (
  input  logic              clk,
  input  logic              load,
  input  logic [31:0]       word,
  input  logic [31:0]       pc,
  input  logic              fp,
  input  logic              vec,
  input  ppcdec_pkg::cfg_t  regs,
  output ppcdec_pkg::dec_t  dec
);

  ppcdec_pkg::dec_t  d;
  ppcdec_pkg::op31_t e31;
  logic [5:0]  prim;
  logic [9:0]  sub10;
  logic [4:0]  sub5;
  logic [8:0]  vec_id;
  logic [8:0]  id63b;
  logic [4:0]  vc;
  logic [7:0]  vt;

  assign prim  = word[31:26];
  assign sub10 = word[10:1];
  assign sub5  = word[5:1];
  assign e31   = ppcdec_pkg::op31_lookup(sub10);
  assign id63b = ppcdec_pkg::op63b_id(sub10);
  assign vc    = ppcdec_pkg::vcmp_lookup(sub10[8:0]);
  assign vt    = ppcdec_pkg::vtab_lookup(sub10);

  // opcode 4: multiply-add switch, then compares, then the vector table
  always_comb begin
    vec_id = 9'd0;
    case (sub5)
      5'd16: vec_id = word[0] ? 9'd204 : 9'd205;
      5'd17: vec_id = 9'd206;
      5'd18: vec_id = word[0] ? 9'd207 : 9'd208;
      5'd19: vec_id = word[0] ? 9'd209 : 9'd210;
      5'd20: vec_id = word[0] ? 9'd211 : 9'd212;
      5'd21: vec_id = word[0] ? 9'd213 : 9'd214;
      5'd22: vec_id = 9'd215;
      5'd23: vec_id = word[0] ? 9'd216 : 9'd217;
      default: begin
        if (vc[4]) begin
          vec_id = ppcdec_pkg::BASE_VCMP + {5'd0, vc[3:0]};
        end else if (sub10 < ppcdec_pkg::VEC_EXT_LIMIT && vt[7]) begin
          vec_id = ppcdec_pkg::BASE_VTAB + {2'd0, vt[6:0]};
        end
      end
    endcase
  end

  always_comb begin
    d           = '0;
    d.fp        = fp;
    d.osi_hit   = (pc == regs.osi_entry_address) && (word == regs.osi_magic_word);
    d.hk_memset = (word == ppcdec_pkg::HOOK_MEMSET);
    d.hk_memcpy = (word == ppcdec_pkg::HOOK_MEMCPY);
    d.hk_stop   = (word == ppcdec_pkg::HOOK_STOP);
    case (prim)
      6'd3:  d.id = 9'd1;
      6'd7:  d.id = 9'd2;
      6'd8:  d.id = 9'd3;
      6'd17: d.id = 9'd10;
      6'd4: begin
        if (regs.altivec_present) begin
          if (!vec) d.novec = 1'b1;
          else d.id = vec_id;
        end
      end
      6'd16, 6'd18: begin
        d.id = (prim == 6'd16) ? 9'd41 : 9'd42;
        d.lk = word[0];
        d.aa = word[1];
      end
      6'd19: begin
        d.id = ppcdec_pkg::op19_id(word[10:0]);
        if (d.id == 9'd44 || d.id == 9'd55) d.lk = word[0];
      end
      6'd20: begin d.id = 9'd56; d.rc = word[0]; end
      6'd21: begin d.id = 9'd57; d.rc = word[0]; end
      6'd23: begin d.id = 9'd58; d.rc = word[0]; end
      6'd31: begin
        if (e31.hit && !(e31.kind == ppcdec_pkg::K_VEC && !regs.altivec_present)) begin
          d.id  = ppcdec_pkg::BASE_OP31 + {2'd0, e31.idx};
          d.rc  = (e31.kind == ppcdec_pkg::K_RC) ? word[0] : 1'b0;
          d.fpk = (e31.kind == ppcdec_pkg::K_FP);
        end
      end
      6'd59: begin
        d.id  = ppcdec_pkg::op59_id(sub5);
        d.fpk = 1'b1;
      end
      6'd63: begin
        d.id  = (id63b != 9'd0) ? id63b : ppcdec_pkg::op63a_id(sub5);
        d.fpk = 1'b1;
      end
      default: begin
        if (prim >= 6'd10 && prim <= 6'd15) begin
          d.id = {3'd0, prim} - 9'd6;
        end else if (prim >= 6'd24 && prim <= 6'd29) begin
          d.id = {3'd0, prim} - 9'd13;
        end else if (prim >= 6'd32 && prim <= 6'd47) begin
          d.id = {3'd0, prim} - 9'd15;
        end else if (prim >= 6'd48 && prim <= 6'd55) begin
          d.id  = {3'd0, prim} - 9'd15;
          d.fpk = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dec <= d;
    end
  end

endmodule

[rtl/powerpc_instruction_decoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// powerpc_instruction_decoder_core
// 32-bit instruction decode with vector extension; unless the output stalls, one word per cycle
// ----------------------------------------------------------------------------
// channel    role   carries
// item_in    sink   instruction_word, program_counter, fp_enabled, vec_enabled
// item_out   source handler_id, decode_status, record/link/absolute flags
// cfg        sink   index 0 altivec, 1 osi entry pc, 2 osi magic word
//
// an item passes the table lookup register, then the status/output register
// throughput one item per cycle while the output is not stalled
// the lookup stage is a set of constant opcode tables read in parallel
// rst is synchronous; it clears valid bits and the config registers
// a stalled output holds; input keeps flowing while the lookup stage is free
// ----------------------------------------------------------------------------
module powerpc_instruction_decoder_core (
  input  logic          clk,
  input  logic          rst,
  ppcdec_in_if.sink     item_in,
  ppcdec_out_if.source  item_out,
  ppcdec_cfg_if.sink    cfg
);

  ppcdec_pkg::cfg_t regs;
  ppcdec_pkg::dec_t dec;
  logic       s1_valid;
  logic       out_adv;
  logic       in_take;
  logic [2:0] status_next;

  ppcdec_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // output register free or draining this cycle
  assign out_adv       = !item_out.valid || item_out.ready;
  assign item_in.ready = !s1_valid || out_adv;
  assign in_take       = item_in.valid && item_in.ready;

  ppcdec_lookup u_lookup (
    .clk  (clk),
    .load (in_take),
    .word (item_in.instruction_word),
    .pc   (item_in.program_counter),
    .fp   (item_in.fp_enabled),
    .vec  (item_in.vec_enabled),
    .regs (regs),
    .dec  (dec)
  );

  // status priority: no vector, then for an unknown word osi, the hook words and illegal, then no fpu
  always_comb begin
    if (dec.novec) begin
      status_next = ppcdec_pkg::ST_NO_VEC;
    end else if (dec.id == 9'd0) begin
      if (dec.osi_hit)        status_next = ppcdec_pkg::ST_OSI;
      else if (dec.hk_memset) status_next = ppcdec_pkg::ST_MEMSET;
      else if (dec.hk_memcpy) status_next = ppcdec_pkg::ST_MEMCPY;
      else if (dec.hk_stop)   status_next = ppcdec_pkg::ST_STOP;
      else                    status_next = ppcdec_pkg::ST_ILLEGAL;
    end else if (dec.fpk && !dec.fp) begin
      status_next = ppcdec_pkg::ST_NO_FPU;
    end else begin
      status_next = ppcdec_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      item_out.valid <= 1'b0;
    end else begin
      if (item_in.ready) s1_valid <= item_in.valid;
      if (out_adv) item_out.valid <= s1_valid;
    end
  end

  // result payload, flags cleared unless the status is ok
  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      item_out.decode_status <= status_next;
      if (status_next == ppcdec_pkg::ST_OK) begin
        item_out.handler_id    <= dec.id;
        item_out.record_flag   <= dec.rc;
        item_out.link_flag     <= dec.lk;
        item_out.absolute_flag <= dec.aa;
      end else begin
        item_out.handler_id    <= 9'd0;
        item_out.record_flag   <= 1'b0;
        item_out.link_flag     <= 1'b0;
        item_out.absolute_flag <= 1'b0;
      end
    end
  end

  // a failed status never carries a handler or flags
  a_bad_status_clean: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && item_out.decode_status != ppcdec_pkg::ST_OK |->
      item_out.handler_id == 9'd0 && !item_out.record_flag &&
      !item_out.link_flag && !item_out.absolute_flag)
    else $error("flags or handler set on failed decode");

  // an ok status always names a handler
  a_ok_has_id: assert property (@(posedge clk) disable iff (rst)
    item_out.valid && item_out.decode_status == ppcdec_pkg::ST_OK |->
      item_out.handler_id != 9'd0)
    else $error("ok decode without handler");

  // no item is taken over a held lookup stage
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |-> !in_take)
    else $error("lookup stage overwritten while stalled");

  // a held lookup stage keeps its item
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_adv |=> s1_valid)
    else $error("lookup stage lost an item");

endmodule
